FILE: rtl/core/ced_pkg.sv
// ----------------------------------------------------------------------------
// ced_pkg: shared types and constants of the C escape decoder
// Item types of both channels, the classified character passed from the
// front to the back, the escape modes, the result kinds and the queue status.
// ----------------------------------------------------------------------------
package ced_pkg;

  // Escape value width and octal digit limit.
  localparam int ACC_BITS     = 63;
  localparam int OCTAL_DIGITS = 3;
  localparam int VALUE_W      = 63;

  // Queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [ACC_BITS-1:0] ACC_MAX = {ACC_BITS{1'b1}};

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_PLAIN = 2'd0,
    KIND_HEX   = 2'd1,
    KIND_OCT   = 2'd2,
    KIND_BAD   = 2'd3
  } kind_t;

  // Escape modes of the back part.
  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_BSL  = 2'd1,
    MODE_HEX  = 2'd2,
    MODE_OCT  = 2'd3
  } mode_t;

  // One input item.
  typedef struct packed {
    logic [7:0] ch;
    logic       final_char;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    kind_t              kind;
    logic               run_end;
  } out_item_t;

  // A character after classification.
  typedef struct packed {
    logic [7:0] ch;
    logic       final_char;
    logic       is_bsl;
    logic       is_x;
    logic       named_ok;
    logic [7:0] named_val;
    logic       is_oct;
    logic       is_hex;
    logic [3:0] digit;
  } cls_item_t;

  // Queue status seen by the back part.
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

FILE: rtl/core/c_escape_decoder.sv
// ----------------------------------------------------------------------------
// c_escape_decoder: streaming C string escape decoder
// Each character is written into the queue and its result is loaded into the
// result register. Throughput: one character per cycle while out_stall is low;
// a character that yields two results holds the back part for one result
// register load per result. A four-entry queue lets the input keep taking
// characters meanwhile. Reset (synchronous, active low) empties the queue and
// leaves no escape open.
module c_escape_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ced_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ced_pkg::out_item_t out_data
);
  import ced_pkg::*;

  cls_item_t wr_item;
  cls_item_t rd_item;
  q_stat_t   q_stat;
  logic      push;
  logic      pop;

  // Classification of incoming characters.
  ced_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .push     (push),
    .wr_item  (wr_item)
  );

  // Queue between front and back.
  ced_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_item (wr_item),
    .pop     (pop),
    .rd_item (rd_item),
    .q_stat  (q_stat)
  );

  // Escape decoding and result delivery.
  ced_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_item   (rd_item),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // The back part never takes a character from an empty queue.
  assert property (@(posedge clk) disable iff (!rst_n) pop |-> !q_stat.empty)
    else $error("queue popped while empty");

  // The first of two results is always followed by its partner.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.run_end) |=> out_valid)
    else $error("second result of a character missing");

  // Reset leaves no result pending and the queue empty.
  assert property (@(posedge clk) !rst_n |=> (!out_valid && q_stat.empty))
    else $error("state not cleared by reset");

endmodule

FILE: rtl/core/ced_front.sv
// ----------------------------------------------------------------------------
// ced_front: input side of the C escape decoder
// Takes character transfers and classifies each character (backslash, named
// escape letter, hex and octal digit) before it enters the queue.
// ----------------------------------------------------------------------------
module ced_front (
  input  logic               in_valid,
  output logic               in_stall,
  input  ced_pkg::in_item_t  in_data,
  input  ced_pkg::q_stat_t   q_stat,
  output logic               push,
  output ced_pkg::cls_item_t wr_item
);
  import ced_pkg::*;

  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOT = 8'h22;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;

  logic [7:0] c;

  assign c = in_data.ch;

  // The queue accepts a transfer whenever it has room.
  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  // Named escapes and digit classes.
  always_comb begin
    wr_item            = '0;
    wr_item.ch         = c;
    wr_item.final_char = in_data.final_char;
    wr_item.is_bsl     = (c == CH_BSL);
    wr_item.is_x       = (c == CH_X);
    wr_item.is_oct     = (c >= CH_0) && (c <= CH_7);
    wr_item.named_ok   = 1'b1;
    case (c)
      CH_QUOTE: wr_item.named_val = CH_QUOTE;
      CH_DQUOT: wr_item.named_val = CH_DQUOT;
      CH_QMARK: wr_item.named_val = CH_QMARK;
      CH_BSL:   wr_item.named_val = CH_BSL;
      8'h61:    wr_item.named_val = 8'd7;   // a: alert
      8'h62:    wr_item.named_val = 8'd8;   // b: backspace
      8'h66:    wr_item.named_val = 8'd12;  // f: form feed
      8'h6E:    wr_item.named_val = 8'd10;  // n: newline
      8'h72:    wr_item.named_val = 8'd13;  // r: carriage return
      8'h74:    wr_item.named_val = 8'd9;   // t: tab
      8'h76:    wr_item.named_val = 8'd11;  // v: vertical tab
      default: begin
        wr_item.named_ok  = 1'b0;
        wr_item.named_val = 8'd0;
      end
    endcase
    if ((c >= CH_0) && (c <= CH_9)) begin
      wr_item.is_hex = 1'b1;
      wr_item.digit  = 4'(c - CH_0);
    end else if ((c >= CH_LA) && (c <= CH_LF)) begin
      wr_item.is_hex = 1'b1;
      wr_item.digit  = 4'(c - CH_LA + 8'd10);
    end else if ((c >= CH_UA) && (c <= CH_UF)) begin
      wr_item.is_hex = 1'b1;
      wr_item.digit  = 4'(c - CH_UA + 8'd10);
    end else begin
      wr_item.is_hex = 1'b0;
      wr_item.digit  = 4'd0;
    end
  end

endmodule

FILE: rtl/core/ced_fifo.sv
// ----------------------------------------------------------------------------
// ced_fifo: queue of classified characters
// Short first-in first-out queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module ced_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ced_pkg::cls_item_t wr_item,
  input  logic               pop,
  output ced_pkg::cls_item_t rd_item,
  output ced_pkg::q_stat_t   q_stat
);
  import ced_pkg::*;

  cls_item_t      mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   count_r, count_nxt;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QAW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QAW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (QAW+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (QAW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  assign rd_item      = mem_r[rd_ptr_r];
  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == (QAW+1)'(QDEPTH));

endmodule

FILE: rtl/core/ced_back.sv
// ----------------------------------------------------------------------------
// ced_back: escape state machine and result register
// Consumes classified characters from the queue, tracks the open escape and
// delivers up to two results per character, one per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module ced_back (
  input  logic                clk,
  input  logic                rst_n,
  input  ced_pkg::cls_item_t  rd_item,
  input  ced_pkg::q_stat_t    q_stat,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output ced_pkg::out_item_t  out_data
);
  import ced_pkg::*;

  localparam logic [1:0] OCT_LIMIT = 2'(OCTAL_DIGITS);
  localparam bit         OCT_ONE   = (OCTAL_DIGITS <= 1);

  mode_t               mode_r, mode_nxt;
  logic [ACC_BITS-1:0] acc_r, acc_nxt;
  logic [1:0]          cnt_r, cnt_nxt;
  logic                seen_r, seen_nxt;
  logic                second_r, second_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;

  logic                fin;
  logic                idle_emit;
  mode_t               idle_mode;
  logic [VALUE_W-1:0]  idle_val;
  kind_t               idle_kind;
  logic [ACC_BITS-1:0] acc_h, acc_o, oct_first;
  logic [1:0]          cnt_inc;
  logic [1:0]          n_res;
  logic [VALUE_W-1:0]  r0_val, r1_val;
  kind_t               r0_kind, r1_kind;
  logic                load;

  assign fin = rd_item.final_char;

  // Fresh character: a non-final backslash opens an escape, else it is emitted.
  assign idle_emit = !(rd_item.is_bsl && !fin);
  assign idle_mode = (rd_item.is_bsl && !fin) ? MODE_BSL : MODE_IDLE;
  assign idle_val  = rd_item.is_bsl ? '0 : VALUE_W'(rd_item.ch);
  assign idle_kind = rd_item.is_bsl ? KIND_BAD : KIND_PLAIN;

  // Saturating digit accumulation.
  assign acc_h = (|acc_r[ACC_BITS-1 -: 4]) ? ACC_MAX
               : {acc_r[ACC_BITS-5:0], rd_item.digit};
  assign acc_o = (|acc_r[ACC_BITS-1 -: 3]) ? ACC_MAX
               : {acc_r[ACC_BITS-4:0], rd_item.digit[2:0]};
  assign oct_first = ACC_BITS'(rd_item.digit[2:0]);
  assign cnt_inc   = 2'(cnt_r + 2'd1);

  // Results caused by the head character in the present mode.
  always_comb begin
    n_res   = 2'd0;
    r0_val  = '0;
    r0_kind = KIND_PLAIN;
    r1_val  = idle_val;
    r1_kind = idle_kind;
    case (mode_r)
      MODE_IDLE: begin
        if (idle_emit) begin
          n_res   = 2'd1;
          r0_val  = idle_val;
          r0_kind = idle_kind;
        end
      end
      MODE_BSL: begin
        if (rd_item.named_ok) begin
          n_res  = 2'd1;
          r0_val = VALUE_W'(rd_item.named_val);
        end else if (rd_item.is_x) begin
          if (fin) begin
            n_res   = 2'd1;
            r0_kind = KIND_BAD;
          end
        end else if (rd_item.is_oct) begin
          if (fin || OCT_ONE) begin
            n_res   = 2'd1;
            r0_val  = VALUE_W'(oct_first);
            r0_kind = KIND_OCT;
          end
        end else begin
          n_res   = idle_emit ? 2'd2 : 2'd1;
          r0_kind = KIND_BAD;
        end
      end
      MODE_HEX: begin
        if (rd_item.is_hex) begin
          if (fin) begin
            n_res   = 2'd1;
            r0_val  = VALUE_W'(acc_h);
            r0_kind = KIND_HEX;
          end
        end else begin
          n_res   = idle_emit ? 2'd2 : 2'd1;
          r0_val  = seen_r ? VALUE_W'(acc_r) : '0;
          r0_kind = seen_r ? KIND_HEX : KIND_BAD;
        end
      end
      default: begin
        if (rd_item.is_oct) begin
          if (fin || (cnt_inc >= OCT_LIMIT)) begin
            n_res   = 2'd1;
            r0_val  = VALUE_W'(acc_o);
            r0_kind = KIND_OCT;
          end
        end else begin
          n_res   = idle_emit ? 2'd2 : 2'd1;
          r0_val  = VALUE_W'(acc_r);
          r0_kind = KIND_OCT;
        end
      end
    endcase
  end

  // Next escape state, taken when the head character leaves the queue.
  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    seen_nxt = seen_r;
    if (pop) begin
      mode_nxt = MODE_IDLE;
      acc_nxt  = '0;
      cnt_nxt  = 2'd0;
      seen_nxt = 1'b0;
      case (mode_r)
        MODE_IDLE: begin
          mode_nxt = idle_mode;
        end
        MODE_BSL: begin
          if (rd_item.named_ok) begin
            mode_nxt = MODE_IDLE;
          end else if (rd_item.is_x) begin
            mode_nxt = fin ? MODE_IDLE : MODE_HEX;
          end else if (rd_item.is_oct) begin
            if (!(fin || OCT_ONE)) begin
              mode_nxt = MODE_OCT;
              acc_nxt  = oct_first;
              cnt_nxt  = 2'd1;
            end
          end else begin
            mode_nxt = idle_mode;
          end
        end
        MODE_HEX: begin
          if (rd_item.is_hex) begin
            if (!fin) begin
              mode_nxt = MODE_HEX;
              acc_nxt  = acc_h;
              seen_nxt = 1'b1;
            end
          end else begin
            mode_nxt = idle_mode;
          end
        end
        default: begin
          if (rd_item.is_oct) begin
            if (!(fin || (cnt_inc >= OCT_LIMIT))) begin
              mode_nxt = MODE_OCT;
              acc_nxt  = acc_o;
              cnt_nxt  = cnt_inc;
            end
          end else begin
            mode_nxt = idle_mode;
          end
        end
      endcase
    end
  end

  // Result register loading and queue pop.
  assign load = !out_valid_r || !out_stall;

  always_comb begin
    pop           = 1'b0;
    second_nxt    = second_r;
    out_valid_nxt = load ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;
    if (!q_stat.empty) begin
      case (n_res)
        2'd1: begin
          if (load) begin
            pop                  = 1'b1;
            out_valid_nxt        = 1'b1;
            out_data_nxt.value   = r0_val;
            out_data_nxt.kind    = r0_kind;
            out_data_nxt.run_end = 1'b1;
          end
        end
        2'd2: begin
          if (load) begin
            out_valid_nxt = 1'b1;
            if (!second_r) begin
              second_nxt           = 1'b1;
              out_data_nxt.value   = r0_val;
              out_data_nxt.kind    = r0_kind;
              out_data_nxt.run_end = 1'b0;
            end else begin
              pop                  = 1'b1;
              second_nxt           = 1'b0;
              out_data_nxt.value   = r1_val;
              out_data_nxt.kind    = r1_kind;
              out_data_nxt.run_end = 1'b1;
            end
          end
        end
        default: begin
          pop = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      acc_r       <= '0;
      cnt_r       <= 2'd0;
      seen_r      <= 1'b0;
      second_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
      seen_r      <= seen_nxt;
      second_r    <= second_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
